>>> src/positional_list_store_macros.svh
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// checks sampled on the rising edge, held off during reset
`define PLS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checks sampled on the rising edge, also active during reset
`define PLS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> src/pls_pkg.sv
package pls_pkg;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_DELETE  = 3'd1,
      OP_READ    = 3'd2,
      OP_REPLACE = 3'd3,
      OP_CLEAR   = 3'd4
   } pls_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } pls_status_type;

   localparam int POS_W   = 4;
   localparam int WORD_W  = 64;
   localparam int COUNT_W = 5;
   localparam int CMP_W   = 9;

   typedef struct packed {
      logic [2:0]        op;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] entry_in;
   } pls_req_type;

   typedef struct packed {
      pls_status_type     status;
      logic [WORD_W-1:0]  entry_out;
      logic [COUNT_W-1:0] count;
   } pls_rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              load_en;
      logic              shift_back;
      logic              shift_fwd;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] word;
   } pls_cmd_type;

endpackage

>>> src/pls_cell.sv
module pls_cell #(
   parameter int ENTRY_WIDTH = 64,
   parameter int IDX         = 0
) (
   input  logic                     clock,
   input  pls_pkg::pls_cmd_type     cmd,
   input  logic [ENTRY_WIDTH-1:0]   prev_data,
   input  logic [ENTRY_WIDTH-1:0]   next_data,
   output logic [ENTRY_WIDTH-1:0]   data
);
   import pls_pkg::*;

   localparam logic [CMP_W-1:0] IDX_V = CMP_W'(IDX);

   logic [CMP_W-1:0]       pos_ext;
   logic [ENTRY_WIDTH-1:0] data_ff;
   logic [ENTRY_WIDTH-1:0] data_in;

   assign pos_ext = CMP_W'(cmd.pos);

   always_comb begin
      data_in = data_ff;
      if (cmd.load_en && (IDX_V == pos_ext)) begin
         data_in = ENTRY_WIDTH'(cmd.word);
      end else if (cmd.shift_back && (IDX_V > pos_ext)) begin
         data_in = prev_data;
      end else if (cmd.shift_fwd && (IDX_V >= pos_ext)) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> src/positional_list_store.sv
// Positional list store: an ordered list of up to DEPTH entries of ENTRY_WIDTH bits,
// addressed by position from the head. Each request transaction inserts, deletes,
// reads, replaces or clears, and yields exactly one response transaction with a
// status, the read entry (zero unless a read succeeded) and the count held after it.
// The list lives in a chain of DEPTH cells that all shift by one place in the same
// cycle, so every operation, insert and delete included, completes in the cycle it is
// taken: one request per cycle is taken while req_stall is low, and the response appears
// the cycle after. The response sits in a register; while it is stalled, req_stall is high.
module positional_list_store #(
   parameter int DEPTH       = 16,
   parameter int ENTRY_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pls_pkg::pls_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pls_pkg::pls_rsp_type rsp_data
);
   import pls_pkg::*;

`include "positional_list_store_macros.svh"

   localparam int HW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   logic                   req_fire;
   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       held_ext;
   logic [IW-1:0]          rd_idx;
   logic [HW-1:0]          held_ff;
   logic [HW-1:0]          held_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   pls_rsp_type            rsp_ff;
   pls_rsp_type            rsp_in;
   pls_cmd_type            cmd;
   logic [ENTRY_WIDTH-1:0] cell_q [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign pos_ext   = CMP_W'(req_data.pos);
   assign held_ext  = CMP_W'(held_ff);
   assign rd_idx    = pos_ext[IW-1:0];

   always_comb begin
      held_in          = held_ff;
      rsp_in.status    = ST_OK;
      rsp_in.entry_out = '0;
      cmd.load_en      = 1'b0;
      cmd.shift_back   = 1'b0;
      cmd.shift_fwd    = 1'b0;
      cmd.pos          = req_data.pos;
      cmd.word         = req_data.entry_in;
      unique case (req_data.op) inside
         OP_INSERT: begin
            if (held_ff == HW'(DEPTH)) begin
               rsp_in.status = ST_FULL;
            end else if (pos_ext > held_ext) begin
               rsp_in.status = ST_RANGE;
            end else begin
               cmd.load_en    = req_fire;
               cmd.shift_back = req_fire;
               held_in        = held_ff + 1'b1;
            end
         end
         OP_DELETE, OP_READ, OP_REPLACE: begin
            if (held_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else if (pos_ext >= held_ext) begin
               rsp_in.status = ST_RANGE;
            end else if (req_data.op == OP_DELETE) begin
               cmd.shift_fwd = req_fire;
               held_in       = held_ff - 1'b1;
            end else if (req_data.op == OP_READ) begin
               rsp_in.entry_out = WORD_W'(cell_q[rd_idx]);
            end else begin
               cmd.load_en = req_fire;
            end
         end
         OP_CLEAR: begin
            held_in = '0;
         end
         default: begin
         end
      endcase
      rsp_in.count = COUNT_W'(held_in);
   end

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] prev_data;
      logic [ENTRY_WIDTH-1:0] next_data;
      if (gi == 0) begin : g_head
         assign prev_data = '0;
      end else begin : g_mid
         assign prev_data = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
         assign next_data = cell_q[gi];
      end else begin : g_body
         assign next_data = cell_q[gi+1];
      end
      pls_cell #(
         .ENTRY_WIDTH (ENTRY_WIDTH),
         .IDX         (gi)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .prev_data (prev_data),
         .next_data (next_data),
         .data      (cell_q[gi])
      );
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PLS_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid_ff, "response valid after reset")
   `PLS_ASSERT(a_held_bound, held_ff <= HW'(DEPTH), "held count exceeds depth")
   `PLS_ASSERT(a_count_match, rsp_valid_ff |-> rsp_ff.count == COUNT_W'(held_ff),
      "response count differs from held count")
   `PLS_ASSERT(a_fire_to_rsp, req_fire |=> rsp_valid_ff, "accepted request produced no response")
   `PLS_ASSERT(a_full_count, rsp_valid_ff && rsp_ff.status == ST_FULL |-> held_ff == HW'(DEPTH),
      "full status with room left")

endmodule

>>> verif/tb_positional_list_store.sv
`timescale 1ns / 100ps

module tb_positional_list_store;
   import pls_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int ITEM_TARGET = 1850;
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_LAST = 3'd7;

   typedef struct {
      pls_req_type req;
      int gap;
      bit pause;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pls_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pls_rsp_type rsp_data;

   stim_type stim_q[$];
   pls_rsp_type expected_rsp_q[$];
   pls_rsp_type exp_rsp;
   logic [WORD_W-1:0] shadow_cells[LIST_DEPTH];
   int shadow_held = 0;
   int gen_held = 0;
   int gap_left = 0;
   int stall_left = 0;
   int stall_draw;
   bit sink_calm = 1'b0;
   int outstanding = 0;
   int idle_cycles = 0;
   int mismatch_count = 0;

   positional_list_store dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // updates the shadow list and returns the response the block must give
   function automatic pls_rsp_type apply_list_op(pls_req_type r);
      pls_rsp_type o;
      o.status = ST_OK;
      o.entry_out = '0;
      case (r.op)
         OP_INSERT: begin
            if (shadow_held >= LIST_DEPTH) begin
               o.status = ST_FULL;
            end else if (r.pos > shadow_held) begin
               o.status = ST_RANGE;
            end else begin
               for (int k = shadow_held; k > r.pos; k--) shadow_cells[k] = shadow_cells[k-1];
               shadow_cells[r.pos] = r.entry_in;
               shadow_held++;
            end
         end
         OP_DELETE, OP_READ, OP_REPLACE: begin
            if (shadow_held == 0) begin
               o.status = ST_EMPTY;
            end else if (r.pos >= shadow_held) begin
               o.status = ST_RANGE;
            end else if (r.op == OP_DELETE) begin
               for (int k = r.pos; k + 1 < shadow_held; k++) shadow_cells[k] = shadow_cells[k+1];
               shadow_held--;
            end else if (r.op == OP_READ) begin
               o.entry_out = shadow_cells[r.pos];
            end else begin
               shadow_cells[r.pos] = r.entry_in;
            end
         end
         OP_CLEAR: shadow_held = 0;
         default: ;
      endcase
      o.count = COUNT_W'(shadow_held);
      return o;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // appends one transaction and tracks the list length seen by the generator
   task automatic queue_op(logic [2:0] op, int pos, logic [WORD_W-1:0] word, int gap);
      stim_type s;
      s.req.op = op;
      s.req.pos = POS_W'(pos);
      s.req.entry_in = word;
      s.gap = gap;
      s.pause = 1'b0;
      stim_q.push_back(s);
      if (op == OP_INSERT && gen_held < LIST_DEPTH && pos <= gen_held) gen_held++;
      else if (op == OP_DELETE && pos < gen_held) gen_held--;
      else if (op == OP_CLEAR) gen_held = 0;
   endtask

   task automatic queue_pause();
      stim_type s;
      s.req = '0;
      s.gap = 0;
      s.pause = 1'b1;
      stim_q.push_back(s);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (stim_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (stim_q[0].pause) begin
            req_valid <= 1'b0;
            if (!req_valid && outstanding == 0) void'(stim_q.pop_front());
         end else if (stim_q[0].gap > 0) begin
            req_valid <= 1'b0;
            gap_left <= stim_q[0].gap - 1;
            stim_q[0].gap = 0;
         end else begin
            req_valid <= 1'b1;
            req_data <= stim_q[0].req;
            void'(stim_q.pop_front());
         end
      end
   end

   // response sink
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
         stall_draw = sink_calm ? 0 : $urandom_range(0, 15);
         stall_left <= stall_draw;
         rsp_stall <= (stall_draw != 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         outstanding <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%t unexpected rsp transaction: status %0d entry %h count %0d",
                           $time, rsp_data.status, rsp_data.entry_out, rsp_data.count);
               mismatch_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_data.status !== exp_rsp.status ||
                   rsp_data.entry_out !== exp_rsp.entry_out ||
                   rsp_data.count !== exp_rsp.count) begin
                  if (mismatch_count < 10)
                     $display("%t rsp mismatch: expected status %0d entry %h count %0d, %s",
                              $time, exp_rsp.status, exp_rsp.entry_out, exp_rsp.count,
                              $sformatf("got status %0d entry %h count %0d", rsp_data.status,
                                        rsp_data.entry_out, rsp_data.count));
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) expected_rsp_q.push_back(apply_list_op(req_data));
         outstanding <= outstanding + int'(req_valid && !req_stall)
                        - int'(rsp_valid && !rsp_stall);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int mode, seg_len, ins_w, del_w, w, pos, gap, item_total;
      bit send_calm;
      logic [2:0] op;

      // empty list, range errors, head and tail inserts, spare codes
      queue_op(OP_READ, 0, '0, $urandom_range(0, 15));
      queue_op(OP_DELETE, 0, '0, $urandom_range(0, 15));
      queue_op(OP_REPLACE, 15, '1, $urandom_range(0, 15));
      queue_op(OP_INSERT, 1, 64'h0f0f_0f0f_0f0f_0f0f, 0);
      queue_op(OP_INSERT, 0, '1, 0);
      queue_op(OP_INSERT, 0, '0, $urandom_range(0, 15));
      queue_op(OP_INSERT, 2, 64'h0123_4567_89ab_cdef, 0);
      queue_op(OP_INSERT, 1, 64'hfedc_ba98_7654_3210, 0);
      queue_op(OP_READ, 0, '1, 0);
      queue_op(OP_READ, 3, '0, 0);
      queue_op(OP_READ, 4, '0, $urandom_range(0, 15));
      queue_op(OP_INSERT, 15, '1, 0);
      queue_op(OP_REPLACE, 3, 64'h5555_aaaa_5555_aaaa, 0);
      queue_op(OP_READ, 3, '0, 0);
      queue_op(OP_DELETE, 0, '1, 0);
      queue_op(OP_DELETE, 3, '0, $urandom_range(0, 15));
      queue_op(OP_READ, 15, '0, 0);
      queue_op(OP_SPARE_FIRST, 0, '1, 0);
      queue_op(OP_SPARE_MID, 7, rand_word(), 0);
      queue_op(OP_SPARE_LAST, 15, rand_word(), 0);
      queue_op(OP_CLEAR, 9, '1, 0);
      queue_op(OP_READ, 0, '0, 0);
      queue_op(OP_DELETE, 15, '0, 0);
      queue_pause();
      item_total = 20;

      // segments that grow, shrink or churn the list
      while (item_total < ITEM_TARGET) begin
         mode = $urandom_range(0, 2);
         seg_len = $urandom_range(20, 60);
         send_calm = ($urandom_range(0, 3) == 0);
         ins_w = (mode == 0) ? 55 : (mode == 1) ? 15 : 35;
         del_w = (mode == 0) ? 12 : (mode == 1) ? 50 : 25;
         for (int i = 0; i < seg_len; i++) begin
            w = $urandom_range(0, 99);
            if (w < ins_w) op = OP_INSERT;
            else if (w < ins_w + del_w) op = OP_DELETE;
            else if (w < ins_w + del_w + 2) op = OP_CLEAR;
            else if (w < ins_w + del_w + 4) op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else if (w % 3 == 0) op = OP_REPLACE;
            else op = OP_READ;
            if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 15);
            else if (op == OP_INSERT) pos = $urandom_range(0, (gen_held > 15) ? 15 : gen_held);
            else if (gen_held == 0) pos = $urandom_range(0, 15);
            else pos = $urandom_range(0, gen_held - 1);
            gap = send_calm ? 0 : $urandom_range(0, 15);
            queue_op(op, pos, rand_word(), gap);
            if (op <= OP_CLEAR) item_total++;
         end
         if ($urandom_range(0, 5) == 0) queue_pause();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (stim_q.size() != 0 || req_valid || outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> positional_list_store.f
+incdir+src
src/pls_pkg.sv
src/pls_cell.sv
src/positional_list_store.sv
verif/tb_positional_list_store.sv
